FILE: sv/wsg3_pkg.sv
// Shared types and constants of the three-voice wavetable sound generator.
// Used by every module of the block; depends on nothing else.
package wsg3_pkg;

	typedef enum logic [1:0] {
		OP_REG  = 2'd0,
		OP_WAVE = 2'd1,
		OP_TICK = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] addr;
		logic [3:0] data;
	} cmd_t;

	typedef struct packed {
		logic [3:0] voice_count;
		logic [9:0] mix_gain;
	} cfg_t;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_VOICE_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIX_GAIN    = 2'd1;
	localparam logic [3:0] VOICE_COUNT_RESET = 4'd3;
	localparam logic [9:0] MIX_GAIN_RESET    = 10'd16;

	localparam int QUEUE_DEPTH = 4;
	localparam int REG_COUNT   = 32;
	localparam int WAVE_DEPTH  = 256;
	localparam int WAVE_LEN    = 32;

	localparam int REG_WAVE_SEL = 'h05;
	localparam int REG_FREQ_LO  = 'h10;
	localparam int REG_VOLUME   = 'h15;
	localparam int VOICE_STRIDE = 5;

	localparam logic [6:0] SAMPLE_MAX = 7'd127;
	localparam logic signed [4:0] WAVE_MID = 5'sd8;

	// ceil(2^16 / d), d = 1..15; exact quotient for dividends below 2^11
	localparam logic [16:0] RECIP [16] = '{
		17'd65536, 17'd65536, 17'd32768, 17'd21846,
		17'd16384, 17'd13108, 17'd10923, 17'd9363,
		17'd8192,  17'd7282,  17'd6554,  17'd5958,
		17'd5462,  17'd5042,  17'd4682,  17'd4370
	};

endpackage

FILE: sv/wavetable_sound_generator_3voice_unit.sv
// Three-voice wavetable sound generator, top level.
// Holds the configuration registers and joins wsg3_front, wsg3_fifo and wsg3_back.
//
// Input items arrive on the s_ stream: s_tuser carries the operation (register
// write, wave write, tick), s_tdata the address and the nibble. Register and
// wave writes give no result; each tick gives one signed sample on the m_
// stream. An input item passes the input stage register and waits in a
// four-entry queue. The engine takes one write per cycle while idle. A tick
// walks the voices one per cycle through the wave memory read port, then
// mixes, applies multiply-by-reciprocal scaling and outputs; the engine
// takes no new item until the tick has been output.
// The result waits in an output register; while the receiver stalls, the
// queue keeps filling and s_tready falls once it is full.
// Reset clears the sound registers, the phases, the queue and the output, and
// sets voice_count to 3 and mix_gain to 16; the wave memory keeps its old contents until
// written. The cfg_ port is always ready; the user writes it only while idle (not checked).
module wavetable_sound_generator_3voice_unit #(
	parameter int VOICE_SLOTS       = 3,
	parameter int WAVE_SELECT_COUNT = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,  // address [7:0], data [11:8], zero [15:12]
	input  logic [1:0]                       s_tuser,  // operation [1:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [15:0]                      m_tdata,  // sample [15:0]
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wsg3_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [9:0]                       cfg_data
);
	import wsg3_pkg::*;

	cfg_t cfg_q;
	logic fq_valid;
	logic fq_ready;
	cmd_t fq_cmd;
	logic bq_valid;
	logic bq_ready;
	cmd_t bq_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.voice_count <= VOICE_COUNT_RESET;
			cfg_q.mix_gain    <= MIX_GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_VOICE_COUNT) begin
				cfg_q.voice_count <= cfg_data[3:0];
			end else if (cfg_index == CFG_MIX_GAIN) begin
				cfg_q.mix_gain <= cfg_data;
			end
		end
	end

	wsg3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready),
		.cmd       (fq_cmd)
	);

	wsg3_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cmd   (fq_cmd),
		.pop_valid  (bq_valid),
		.pop_ready  (bq_ready),
		.pop_cmd    (bq_cmd)
	);

	wsg3_back #(
		.VOICE_SLOTS       (VOICE_SLOTS),
		.WAVE_SELECT_COUNT (WAVE_SELECT_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (bq_valid),
		.cmd_ready (bq_ready),
		.cmd       (bq_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

FILE: sv/wsg3_front.sv
// Input stage: takes items from the stream, drops unused operations,
// wraps register offsets and hands commands to the queue. Uses wsg3_pkg.
module wsg3_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [15:0]        s_tdata,  // address [7:0], data [11:8], zero [15:12]
	input  logic [1:0]         s_tuser,  // operation [1:0]
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output wsg3_pkg::cmd_t     cmd
);
	import wsg3_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	op_t  op_in;

	assign op_in     = op_t'(s_tuser);
	assign s_tready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid && (op_in != OP_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1.op   <= op_in;
			cmd_s1.addr <= (op_in == OP_REG) ? {3'd0, s_tdata[4:0]} : s_tdata[7:0];
			cmd_s1.data <= s_tdata[11:8];
		end
	end

endmodule

FILE: sv/wsg3_fifo.sv
// Short command queue between the input stage and the engine.
// Uses wsg3_pkg for the command type and depth.
module wsg3_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  wsg3_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output wsg3_pkg::cmd_t pop_cmd
);
	import wsg3_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != (PW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: sv/wsg3_back.sv
// Engine: register file, wave memory, phase accumulators and the mixer.
// Walks the voices one per cycle on a tick, then scales and saturates. Uses wsg3_pkg.
module wsg3_back #(
	parameter int VOICE_SLOTS       = 3,
	parameter int WAVE_SELECT_COUNT = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  wsg3_pkg::cfg_t cfg,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  wsg3_pkg::cmd_t cmd,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [15:0]    m_tdata   // sample [15:0]
);
	import wsg3_pkg::*;

	localparam int VW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_VOICE,
		S_DRAIN,
		S_MIX,
		S_SCALE,
		S_OUT
	} state_t;

	state_t      state_q;
	logic [VW-1:0] vidx_q;
	logic        out_valid_q;
	logic [15:0] out_q;

	logic [3:0]  regs_q [REG_COUNT];
	logic [3:0]  wave_mem [WAVE_DEPTH];
	logic [3:0]  wave_rd_q;
	logic [19:0] phase_q [VOICE_SLOTS];

	logic [19:0] v_freq [VOICE_SLOTS];
	logic [3:0]  v_vol  [VOICE_SLOTS];
	logic [2:0]  v_sel  [VOICE_SLOTS];
	logic [2:0]  sel_wrap [8];

	logic [3:0]  vc_eff;
	logic [19:0] cur_freq;
	logic [3:0]  cur_vol;
	logic [19:0] phase_next;
	logic        cur_active;
	logic [7:0]  rd_addr;
	logic        pop;

	logic               act_s1;
	logic [3:0]         vol_s1;
	logic signed [4:0]  smp;
	logic signed [4:0]  volx;
	logic signed [9:0]  prod;
	logic signed [9:0]  sum_q;

	logic [9:0]  mag;
	logic [10:0] lim;
	logic [10:0] mag_sat;
	logic        neg_q;
	logic [20:0] mix_q;
	logic [16:0] q_div;
	logic        sat_q;
	logic [27:0] quot_q;
	logic [6:0]  val;
	logic [15:0] mag16;

	for (genvar i = 0; i < 8; i++) begin : g_sel
		assign sel_wrap[i] = 3'(i % WAVE_SELECT_COUNT);
	end

	for (genvar v = 0; v < VOICE_SLOTS; v++) begin : g_voice
		localparam int B = v * VOICE_STRIDE;
		if (v == 0) begin : g_full
			assign v_freq[v] = {regs_q[REG_FREQ_LO+B+4], regs_q[REG_FREQ_LO+B+3],
				regs_q[REG_FREQ_LO+B+2], regs_q[REG_FREQ_LO+B+1], regs_q[REG_FREQ_LO]};
		end else begin : g_coarse
			assign v_freq[v] = {regs_q[REG_FREQ_LO+B+4], regs_q[REG_FREQ_LO+B+3],
				regs_q[REG_FREQ_LO+B+2], regs_q[REG_FREQ_LO+B+1], 4'h0};
		end
		assign v_vol[v] = regs_q[REG_VOLUME+B];
		assign v_sel[v] = sel_wrap[regs_q[REG_WAVE_SEL+B][2:0]];
	end

	assign vc_eff     = (cfg.voice_count == '0) ? 4'd1 : cfg.voice_count;
	assign cur_freq   = v_freq[vidx_q];
	assign cur_vol    = v_vol[vidx_q];
	assign phase_next = phase_q[vidx_q] + cur_freq;
	assign cur_active = (cur_vol != '0) && (cur_freq != '0) && (4'(vidx_q) < vc_eff);
	assign rd_addr    = {v_sel[vidx_q], phase_next[19:15]};
	assign cmd_ready  = (state_q == S_IDLE);
	assign pop        = cmd_valid && cmd_ready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	assign smp  = $signed({1'b0, wave_rd_q}) - WAVE_MID;
	assign volx = $signed({1'b0, vol_s1});
	assign prod = smp * volx;

	assign mag     = sum_q[9] ? 10'(-sum_q) : 10'(sum_q);
	assign lim     = {vc_eff - 4'd1, 7'h7F};
	assign mag_sat = ({1'b0, mag} > lim) ? lim : {1'b0, mag};
	assign q_div   = mix_q[20:4];
	assign val     = sat_q ? SAMPLE_MAX : quot_q[22:16];
	assign mag16   = {1'b0, val, 8'h00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vidx_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && m_tready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					vidx_q <= '0;
					if (pop && cmd.op == OP_TICK) begin
						state_q <= S_VOICE;
					end
				end
				S_VOICE: begin
					if (vidx_q == VW'(VOICE_SLOTS - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						vidx_q <= vidx_q + 1'b1;
					end
				end
				S_DRAIN: state_q <= S_MIX;
				S_MIX:   state_q <= S_SCALE;
				S_SCALE: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_q       <= neg_q ? (16'd0 - mag16) : mag16;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				regs_q[i] <= '0;
			end
		end else if (pop && cmd.op == OP_REG) begin
			regs_q[cmd.addr[4:0]] <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICE_SLOTS; i++) begin
				phase_q[i] <= '0;
			end
		end else if (state_q == S_VOICE && cur_active) begin
			phase_q[vidx_q] <= phase_next;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cmd.op == OP_WAVE) begin
			wave_mem[cmd.addr] <= cmd.data;
		end
		if (state_q == S_VOICE) begin
			wave_rd_q <= wave_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			sum_q  <= '0;
		end else begin
			act_s1 <= (state_q == S_VOICE) && cur_active;
			if (pop && cmd.op == OP_TICK) begin
				sum_q <= '0;
			end else if (act_s1) begin
				sum_q <= sum_q + prod;
			end
		end
	end

	always_ff @(posedge clk) begin
		vol_s1 <= cur_vol;
		if (state_q == S_MIX) begin
			neg_q <= sum_q[9];
			mix_q <= {10'd0, mag_sat} * {11'd0, cfg.mix_gain};
		end
		if (state_q == S_SCALE) begin
			sat_q  <= (q_div >= {6'd0, vc_eff, 7'd0});
			quot_q <= {17'd0, q_div[10:0]} * {11'd0, RECIP[vc_eff]};
		end
	end

endmodule
